@@ hdl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Shared constants, codes, item types and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_IP      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_MAC     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NIC_PRESENT = 2'd2;

   localparam logic [10:0] MIN_PACKET_BYTES = 11'd28;
   localparam logic [15:0] HW_ETHERNET      = 16'h0001;
   localparam logic [15:0] PROTO_IPV4       = 16'h0800;
   localparam logic [7:0]  HW_ADDR_BYTES    = 8'd6;
   localparam logic [7:0]  PROTO_ADDR_BYTES = 8'd4;
   localparam logic [15:0] ARP_OPC_REQUEST  = 16'd1;

   localparam logic [31:0] IP_BROADCAST  = 32'hFFFF_FFFF;
   localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

   localparam logic [0:0] OP_PACKET = 1'b0;
   localparam logic [0:0] OP_QUERY  = 1'b1;

   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_REPLY      = 3'd1;
   localparam logic [2:0] ACT_RESOLVED   = 3'd2;
   localparam logic [2:0] ACT_REQ_SENT   = 3'd3;
   localparam logic [2:0] ACT_MISS_NOREQ = 3'd4;

   localparam logic [1:0] OUT_OPC_NONE    = 2'd0;
   localparam logic [1:0] OUT_OPC_REQUEST = 2'd1;
   localparam logic [1:0] OUT_OPC_REPLY   = 2'd2;

   typedef struct packed {
      logic [0:0]  op;
      logic [10:0] packet_length;
      logic [15:0] hardware_type;
      logic [15:0] protocol_type;
      logic [7:0]  hardware_length;
      logic [7:0]  protocol_length;
      logic [15:0] arp_opcode;
      logic [47:0] src_mac;
      logic [31:0] src_ip;
      logic [31:0] packet_target_ip;
      logic [31:0] query_ip;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [47:0] frame_dest_mac;
      logic [1:0]  out_opcode;
      logic [47:0] out_target_mac;
      logic [31:0] out_target_ip;
      logic [47:0] resolved_mac;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic learn;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic pkt_ok;
      logic bcast;
      logic scan_hit;
      logic scan_miss;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/arpc_controller.sv @@
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences the check, the table scan, the learning write and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  arpc_pkg::status_type status,
   output arpc_pkg::cmd_type    cmd
);

   arpc_pkg::state_type state_ff, state_in;
   logic                early_done;
   logic                scan_done;

   assign early_done = status.is_query ? status.bcast : !status.pkt_ok;
   assign scan_done  = status.scan_hit || status.scan_miss;
   assign busy       = (state_ff != arpc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arpc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = arpc_pkg::ST_CHECK;
            end
         end
         arpc_pkg::ST_CHECK: begin
            state_in = early_done ? arpc_pkg::ST_IDLE : arpc_pkg::ST_SCAN;
         end
         arpc_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = arpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         arpc_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         arpc_pkg::ST_CHECK: begin
            cmd.finish = early_done;
         end
         arpc_pkg::ST_SCAN: begin
            cmd.scan_step = !scan_done;
            cmd.learn     = scan_done && !status.is_query;
            cmd.finish    = scan_done;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_accept_to_check : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == arpc_pkg::ST_CHECK))
      else $error("Accepted item did not enter the check state.");

   a_finish_to_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("Controller still busy after finishing an item.");

   a_learn_only_packets : assert property (@(posedge clock) disable iff (reset)
      cmd.learn |-> (cmd.finish && !status.is_query && status.pkt_ok))
      else $error("Learning write issued for a query or a dropped packet.");

endmodule

`default_nettype wire

@@ hdl/arpc_datapath.sv @@
// ----------------------------------------------------------------------------
// ARP cache datapath
// Holds the configuration, the cache table, the scan pipeline and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  arpc_pkg::req_item_type               req_item,
   input  arpc_pkg::cmd_type                    cmd,
   output arpc_pkg::status_type                 status,
   input  wire                                  csr_valid,
   input  wire  [arpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [arpc_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_valid,
   output arpc_pkg::rsp_item_type               rsp_item
);

   logic [31:0] own_ip_ff;
   logic        nic_present_ff;

   arpc_pkg::req_item_type req_ff;

   logic [31:0] mem_ip  [arpc_pkg::TABLE_ENTRIES];
   logic [47:0] mem_mac [arpc_pkg::TABLE_ENTRIES];
   logic [31:0] rd_ip_ff;
   logic [47:0] rd_mac_ff;

   logic [arpc_pkg::TABLE_ENTRIES-1:0] valid_ff;
   logic [arpc_pkg::CNT_W-1:0]         fill_ff, fill_in;
   logic [arpc_pkg::CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [arpc_pkg::IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                               pend_ff, pend_in;

   logic                       table_full;
   logic [31:0]                key_ip;
   logic                       rd_more;
   logic                       mem_we;
   logic [arpc_pkg::IDX_W-1:0] wr_idx;

   arpc_pkg::rsp_item_type rsp_in;
   arpc_pkg::rsp_item_type rsp_item_ff;
   logic                   rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff      <= '0;
         nic_present_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            arpc_pkg::CSR_OWN_IP:      own_ip_ff      <= csr_data[31:0];
            arpc_pkg::CSR_NIC_PRESENT: nic_present_ff <= csr_data[0];
            // The own MAC is accepted but not stored here.
            arpc_pkg::CSR_OWN_MAC:     ;
            default:                   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   assign status.is_query = (req_ff.op == arpc_pkg::OP_QUERY);
   assign status.pkt_ok   = (req_ff.packet_length >= arpc_pkg::MIN_PACKET_BYTES)
                         && (req_ff.hardware_type == arpc_pkg::HW_ETHERNET)
                         && (req_ff.protocol_type == arpc_pkg::PROTO_IPV4)
                         && (req_ff.hardware_length == arpc_pkg::HW_ADDR_BYTES)
                         && (req_ff.protocol_length == arpc_pkg::PROTO_ADDR_BYTES);
   assign status.bcast    = (req_ff.query_ip == arpc_pkg::IP_BROADCAST);

   assign key_ip  = status.is_query ? req_ff.query_ip : req_ff.src_ip;
   assign rd_more = (rd_idx_ff < fill_ff);

   assign status.scan_hit  = pend_ff && valid_ff[cmp_idx_ff] && (rd_ip_ff == key_ip);
   assign status.scan_miss = !pend_ff && !rd_more;

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      pend_in    = pend_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         pend_in   = 1'b0;
      end else if (cmd.scan_step) begin
         pend_in = rd_more;
         if (rd_more) begin
            rd_idx_in  = rd_idx_ff + 1'b1;
            cmp_idx_in = rd_idx_ff[arpc_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
      end
      cmp_idx_ff <= cmp_idx_in;
   end

   assign table_full = (fill_ff == arpc_pkg::CNT_W'(arpc_pkg::TABLE_ENTRIES));
   assign mem_we     = cmd.learn;

   always_comb begin
      fill_in = fill_ff;
      if (status.scan_hit) begin
         wr_idx = cmp_idx_ff;
      end else if (table_full) begin
         wr_idx = '0;
      end else begin
         wr_idx  = fill_ff[arpc_pkg::IDX_W-1:0];
         fill_in = mem_we ? fill_ff + 1'b1 : fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         valid_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (mem_we) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ip[wr_idx]  <= req_ff.src_ip;
         mem_mac[wr_idx] <= req_ff.src_mac;
      end
      rd_ip_ff  <= mem_ip[rd_idx_ff[arpc_pkg::IDX_W-1:0]];
      rd_mac_ff <= mem_mac[rd_idx_ff[arpc_pkg::IDX_W-1:0]];
   end

   always_comb begin
      rsp_in = '0;
      if (!status.is_query) begin
         if (status.pkt_ok && (req_ff.arp_opcode == arpc_pkg::ARP_OPC_REQUEST)
             && (req_ff.packet_target_ip == own_ip_ff)) begin
            rsp_in.action         = arpc_pkg::ACT_REPLY;
            rsp_in.frame_dest_mac = req_ff.src_mac;
            rsp_in.out_opcode     = arpc_pkg::OUT_OPC_REPLY;
            rsp_in.out_target_mac = req_ff.src_mac;
            rsp_in.out_target_ip  = req_ff.src_ip;
         end
      end else if (status.bcast) begin
         rsp_in.action       = arpc_pkg::ACT_RESOLVED;
         rsp_in.resolved_mac = arpc_pkg::MAC_BROADCAST;
      end else if (status.scan_hit) begin
         rsp_in.action       = arpc_pkg::ACT_RESOLVED;
         rsp_in.resolved_mac = rd_mac_ff;
      end else if (nic_present_ff) begin
         rsp_in.action         = arpc_pkg::ACT_REQ_SENT;
         rsp_in.frame_dest_mac = arpc_pkg::MAC_BROADCAST;
         rsp_in.out_opcode     = arpc_pkg::OUT_OPC_REQUEST;
         rsp_in.out_target_ip  = req_ff.query_ip;
      end else begin
         rsp_in.action = arpc_pkg::ACT_MISS_NOREQ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_item_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_finish_strobe : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("Finished item produced no result strobe.");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= arpc_pkg::CNT_W'(arpc_pkg::TABLE_ENTRIES))
      else $error("Fill count exceeds the table size.");

   a_fill_grows : assert property (@(posedge clock) disable iff (reset)
      (mem_we && !status.scan_hit && !table_full)
      |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("New entry did not advance the fill count.");

endmodule

`default_nettype wire

@@ hdl/arp_cache_and_responder.sv @@
// ----------------------------------------------------------------------------
// ARP cache and responder
// Learns senders of received ARP packets, answers requests for our address
// and resolves IPv4 addresses against a small cache.
//
// An item on req_item is taken at a rising edge with start high and busy low.
// Each item gives exactly one result on rsp_item, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so results are never held back.
// Registers are written over the csr_ channel (index 0 own IP, 1 own MAC,
// 2 NIC present); csr_ready is always high and writes belong to idle time.
// A dropped packet or a broadcast query ends in the check state, and the
// result strobe is registered from there. Otherwise the cache is scanned
// one entry per cycle through the registered table read port, up to the
// fill count, and the scan ends early on a hit.
// One item is in work at a time; busy falls in the cycle the result shows,
// so the next item may be started alongside the result strobe.
// Reset clears the registers, the entry valid bits and the fill count at
// once; table contents are left as they are, and unwritten entries never match.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_and_responder (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  arpc_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   output arpc_pkg::rsp_item_type            rsp_item,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [arpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [arpc_pkg::CSR_DATA_W-1:0]   csr_data
);

   arpc_pkg::cmd_type    cmd;
   arpc_pkg::status_type status;

   assign csr_ready = 1'b1;

   arpc_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   arpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire
